// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the key packer RTL.
// Expects clk and rst in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define SBKP_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SBKP_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/sbkp_pkg.sv -----
// Shared types, constants and helpers for the significant bit key packer.
// No dependencies.
`default_nettype none

package sbkp_pkg;

  localparam int COUNTER_W = 64;
  localparam int SHIFT_W   = 6;
  localparam int NBITS_W   = 7;   // 0..64 significant bits
  localparam int WORD_W    = 32;
  localparam int INDEX_W   = 3;
  localparam int TOTAL_W   = 9;
  localparam int WCNT_W    = 2;   // at most three key words touched per request

  localparam int KEY_WORDS_DEF = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_WRITE,
    ST_EMIT
  } sbkp_state_t;

  typedef struct packed {
    logic load;    // capture request, apply first flag
    logic prep;    // size and align the shifted counter
    logic write;   // store one key word
    logic emit;    // load one result into the output register
  } sbkp_cmd_t;

  typedef struct packed {
    logic last_item;
    logic wcnt_zero;
    logic emit_last;
  } sbkp_status_t;

  // Bit count up to and including the highest set bit.
  function automatic logic [NBITS_W-1:0] sig_bits(input logic [COUNTER_W-1:0] v);
    logic [NBITS_W-1:0] n;
    n = '0;
    for (int i = 0; i < COUNTER_W; i++) begin
      if (v[i]) begin
        n = NBITS_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sbkp_in_if.sv -----
// Request channel of the key packer: valid/ready plus one counter request.
// Depends on sbkp_pkg.
`default_nettype none

interface sbkp_in_if;
  import sbkp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 first_item;
  logic                 last_item;
  logic [COUNTER_W-1:0] counter_value;
  logic [SHIFT_W-1:0]   shift_amount;

  modport source (
    output valid, first_item, last_item, counter_value, shift_amount,
    input  ready
  );

  modport sink (
    input  valid, first_item, last_item, counter_value, shift_amount,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/sbkp_out_if.sv -----
// Result channel of the key packer: valid/ready plus one key word.
// Depends on sbkp_pkg.
`default_nettype none

interface sbkp_out_if;
  import sbkp_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] word_index;
  logic [WORD_W-1:0]  key_word;
  logic [TOTAL_W-1:0] total_bits;
  logic               last_word;

  modport source (
    output valid, word_index, key_word, total_bits, last_word,
    input  ready
  );

  modport sink (
    input  valid, word_index, key_word, total_bits, last_word,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/sbkp_ctrl.sv -----
// Sequencer of the key packer: request handshake, store writes, word emission.
// Depends on sbkp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sbkp_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  output sbkp_pkg::sbkp_cmd_t   cmd,
  input  sbkp_pkg::sbkp_status_t status
);
  import sbkp_pkg::*;

  sbkp_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (status.wcnt_zero) begin
          state_next = status.last_item ? ST_EMIT : ST_IDLE;
        end else begin
          cmd.write = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  `SBKP_CHECK(a_load_to_prep, cmd.load |=> state == ST_PREP, "accepted request did not start prep")
  `SBKP_CHECK(a_no_overwrite, cmd.emit |-> (!out_valid || out_ready), "result overwritten")
  `SBKP_CHECK_ALWAYS(a_reset_out, rst |=> !out_valid, "result valid after reset")

endmodule

`default_nettype wire

// ----- hdl/sbkp_datapath.sv -----
// Datapath of the key packer: shifter, bit sizing, key word store, result register.
// Depends on sbkp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sbkp_datapath #(
  parameter int KEY_WORDS = sbkp_pkg::KEY_WORDS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  sbkp_pkg::sbkp_cmd_t              cmd,
  output sbkp_pkg::sbkp_status_t           status,
  input  wire                              first_item,
  input  wire                              last_item,
  input  wire [sbkp_pkg::COUNTER_W-1:0]    counter_value,
  input  wire [sbkp_pkg::SHIFT_W-1:0]      shift_amount,
  output logic [sbkp_pkg::INDEX_W-1:0]     word_index,
  output logic [sbkp_pkg::WORD_W-1:0]      key_word,
  output logic [sbkp_pkg::TOTAL_W-1:0]     total_bits,
  output logic                             last_word
);
  import sbkp_pkg::*;

  localparam int KEY_BITS = KEY_WORDS * WORD_W;
  localparam int AW       = $clog2(KEY_WORDS);
  localparam int PW       = $clog2(KEY_BITS + 1);
  localparam int WIN_W    = 3 * WORD_W;

  logic [WORD_W-1:0]    mem [KEY_WORDS];
  logic [KEY_WORDS-1:0] valid;

  logic [COUNTER_W-1:0] vreg;
  logic                 last_flag;
  logic [PW-1:0]        pos;
  logic [WORD_W-1:0]    partial;
  logic [WIN_W-1:0]     win;
  logic [WCNT_W-1:0]    wcnt;
  logic [AW-1:0]        waddr;
  logic                 end_aligned;
  logic [AW-1:0]        eidx;

  // prep-cycle sizing
  logic [NBITS_W-1:0]   nbits;
  logic [PW-1:0]        room;
  logic [NBITS_W-1:0]   take;
  logic [COUNTER_W-1:0] mask;
  logic [4:0]           ofs;
  logic [PW-1:0]        pos_sum;
  logic [7:0]           span;
  logic [WIN_W-1:0]     win_new;

  always_comb begin
    nbits   = sig_bits(vreg);
    room    = PW'(KEY_BITS) - pos;
    take    = (PW'(nbits) < room) ? nbits : NBITS_W'(room);
    mask    = (take == NBITS_W'(COUNTER_W)) ? '1 : ~({COUNTER_W{1'b1}} << take);
    ofs     = pos[4:0];
    pos_sum = pos + PW'(take);
    span    = 8'(ofs) + 8'(take) + 8'd31;
    win_new = ({{WORD_W{1'b0}}, vreg & mask} << ofs) | {{(WIN_W-WORD_W){1'b0}}, partial};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      partial <= '0;
      valid   <= '0;
      wcnt    <= '0;
    end else begin
      if (cmd.load && first_item) begin
        pos     <= '0;
        partial <= '0;
        valid   <= '0;
      end
      if (cmd.prep) begin
        pos  <= pos_sum;
        wcnt <= span[6:5];
      end
      if (cmd.write) begin
        valid[waddr] <= 1'b1;
        // the last word written holds the bits below the new position
        partial      <= end_aligned ? '0 : win[WORD_W-1:0];
        wcnt         <= wcnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vreg      <= counter_value >> shift_amount;
      last_flag <= last_item;
      eidx      <= '0;
    end
    if (cmd.prep) begin
      win         <= win_new;
      waddr       <= AW'(pos >> 5);
      end_aligned <= (pos_sum[4:0] == 5'd0);
    end
    if (cmd.write) begin
      mem[waddr] <= win[WORD_W-1:0];
      win        <= win >> WORD_W;
      waddr      <= AW'(waddr + 1'b1);
    end
    if (cmd.emit) begin
      word_index <= INDEX_W'(eidx);
      key_word   <= valid[eidx] ? mem[eidx] : '0;
      total_bits <= TOTAL_W'(pos);
      last_word  <= (eidx == AW'(KEY_WORDS - 1));
      eidx       <= AW'(eidx + 1'b1);
    end
  end

  assign status.last_item = last_flag;
  assign status.wcnt_zero = (wcnt == '0);
  assign status.emit_last = (eidx == AW'(KEY_WORDS - 1));

  `SBKP_CHECK(a_pos_bound, pos <= PW'(KEY_BITS), "bit position beyond key size")
  `SBKP_CHECK(a_write_range, cmd.write |-> (int'(waddr) < KEY_WORDS), "key word write out of range")

endmodule

`default_nettype wire

// ----- hdl/significant_bit_key_packer.sv -----
// Significant bit key packer: each request shifts a 64-bit counter right and appends its
// bits up to the highest set one, LSB first, to a key of KEY_WORDS 32-bit words; bits past
// the key's end are dropped. first_item clears the key first; last_item then returns all
// KEY_WORDS words in order with the total bit count. A request goes through load, prep and
// one write per key word it touches (0 to 3), as the single write port of the key store
// takes one word a cycle; a last request then emits KEY_WORDS results, which the sink can stall.
// Depends on sbkp_pkg, sbkp_in_if, sbkp_out_if, sbkp_ctrl and sbkp_datapath.
`default_nettype none

module significant_bit_key_packer #(
  parameter int KEY_WORDS = sbkp_pkg::KEY_WORDS_DEF
) (
  input wire         clk,
  input wire         rst,
  sbkp_in_if.sink    items,
  sbkp_out_if.source results
);
  import sbkp_pkg::*;

  sbkp_cmd_t    cmd;
  sbkp_status_t status;
  logic         in_ready;
  logic         out_valid;

  sbkp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .status    (status)
  );

  sbkp_datapath #(
    .KEY_WORDS (KEY_WORDS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .first_item    (items.first_item),
    .last_item     (items.last_item),
    .counter_value (items.counter_value),
    .shift_amount  (items.shift_amount),
    .word_index    (results.word_index),
    .key_word      (results.key_word),
    .total_bits    (results.total_bits),
    .last_word     (results.last_word)
  );

  assign items.ready   = in_ready;
  assign results.valid = out_valid;

endmodule

`default_nettype wire
